// ----- hdl/csvt_pkg.sv -----
// Shared types and constants for the CSV field tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] DELIM_RESET = 8'd59;  // ';'
  localparam logic [7:0] QUOTE_RESET = 8'd34;  // '"'

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE     = 1'd1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       record_end;
  } out_t;

  // One queue entry: the results of one input transaction (one or two).
  typedef struct packed {
    logic two;
    out_t r0;
    out_t r1;
  } entry_t;

  typedef struct packed {
    logic [7:0] delimiter_char;
    logic [7:0] quote_char;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ----- hdl/csv_field_tokenizer_top.sv -----
// Top level of the streaming CSV field tokenizer.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one text byte per
//   transaction; in_data.in_last marks the final byte and closes the text.
//   Output channel (out_valid / out_stall / out_data) carries one result per
//   transaction: a content byte and/or field_end / record_end marks.
//   Config port (cfg_we / cfg_index / cfg_wdata) sets the delimiter (index 0)
//   and quote byte (index 1); write only while the block is idle.
// Path: a taken byte's results are written into the result queue, then loaded into the output register.
// Throughput: one input byte per cycle while the queue is not full; the output stage
//   sends one result per cycle while out_stall is low, so a byte that yields two results
//   takes two output transactions. The result queue (FIFO_DEPTH entries) absorbs those bursts.
// Stall: out_stall holds the output register; the queue then fills and
//   in_stall rises only when it is full.
// Reset (rst_n low, synchronous): queue emptied, tokenizer state cleared,
//   delimiter back to ';' and quote to '"'.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_tokenizer_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input byte channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire csvt_pkg::in_t                       in_data,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output csvt_pkg::out_t                           out_data,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [csvt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [csvt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [7:0]           delimiter_char_r;
  logic [7:0]           quote_char_r;
  csvt_pkg::cfg_t       cfg;
  csvt_pkg::fifo_stat_t fstat;
  csvt_pkg::entry_t     push_data;
  csvt_pkg::entry_t     head;
  logic                 push;
  logic                 pop;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_char_r <= csvt_pkg::DELIM_RESET;
      quote_char_r     <= csvt_pkg::QUOTE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        csvt_pkg::CFG_DELIMITER: delimiter_char_r <= cfg_wdata;
        csvt_pkg::CFG_QUOTE:     quote_char_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.delimiter_char = delimiter_char_r;
  assign cfg.quote_char     = quote_char_r;

  // Front end: classifies each byte and produces up to two results
  csvt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fstat     (fstat),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue
  csvt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .fstat     (fstat)
  );

  // Back end: one result per output transaction
  csvt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .fstat     (fstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- hdl/csvt_front.sv -----
// Front end: per-byte classification, tokenizer state and result generation.
`timescale 1ns / 1ps
`default_nettype none

module csvt_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire csvt_pkg::cfg_t      cfg,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire csvt_pkg::in_t       in_data,
  input  wire csvt_pkg::fifo_stat_t fstat,
  output logic                     push,
  output csvt_pkg::entry_t         push_data
);

  logic [7:0] held_byte_r, held_byte_nxt;
  logic held_valid_r, held_valid_nxt;
  logic prev_was_quote_r, prev_was_quote_nxt;
  logic in_quotes_r, in_quotes_nxt;
  logic in_word_r, in_word_nxt;
  logic last_was_delim_r, last_was_delim_nxt;
  logic record_has_data_r, record_has_data_nxt;
  logic prev_was_cr_r, prev_was_cr_nxt;
  logic [1:0] cnt;
  logic accept;

  assign in_stall = fstat.full;
  assign accept   = in_valid && !fstat.full;

  always_comb begin
    logic [7:0] b;
    logic last, take, do_put;
    logic [7:0] put_b;
    csvt_pkg::out_t e, r0, r1;

    b      = in_data.in_byte;
    last   = in_data.in_last;
    take   = 1'b0;
    do_put = 1'b0;
    put_b  = 8'd0;
    e      = '0;
    r0     = '0;
    r1     = '0;
    cnt    = 2'd0;

    held_byte_nxt       = held_byte_r;
    held_valid_nxt      = held_valid_r;
    prev_was_quote_nxt  = prev_was_quote_r;
    in_quotes_nxt       = in_quotes_r;
    in_word_nxt         = in_word_r;
    last_was_delim_nxt  = last_was_delim_r;
    record_has_data_nxt = record_has_data_r;
    prev_was_cr_nxt     = prev_was_cr_r;

    // Pending quote is resolved by this byte.
    if (prev_was_quote_r) begin
      if (b == cfg.quote_char) begin
        prev_was_quote_nxt  = 1'b0;
        prev_was_cr_nxt     = 1'b0;
        record_has_data_nxt = 1'b1;
        last_was_delim_nxt  = 1'b0;
        if (!in_word_r) begin
          // pair opening a field: withhold it
          held_byte_nxt  = cfg.quote_char;
          held_valid_nxt = 1'b1;
          in_word_nxt    = 1'b1;
        end else begin
          do_put = 1'b1;
          put_b  = cfg.quote_char;
        end
      end else begin
        // lone quote toggles quoted mode
        prev_was_quote_nxt  = 1'b0;
        in_quotes_nxt       = !in_quotes_r;
        in_word_nxt         = 1'b1;
        last_was_delim_nxt  = 1'b0;
        record_has_data_nxt = 1'b1;
        take                = 1'b1;
      end
    end else begin
      take = 1'b1;
    end

    if (take) begin
      if (!in_quotes_nxt && (b == csvt_pkg::CHAR_CR || b == csvt_pkg::CHAR_LF)) begin
        if (b == csvt_pkg::CHAR_LF && prev_was_cr_nxt) begin
          prev_was_cr_nxt = 1'b0;   // LF of a CRLF pair
        end else begin
          if (record_has_data_nxt) begin
            e = '{out_byte: 8'd0, byte_valid: 1'b0, field_end: in_word_nxt,
                  record_end: 1'b1};
            if (cnt == 2'd0) r0 = e; else r1 = e;
            cnt = cnt + 2'd1;
          end
          in_word_nxt         = 1'b0;
          held_valid_nxt      = 1'b0;
          last_was_delim_nxt  = 1'b0;
          record_has_data_nxt = 1'b0;
          prev_was_cr_nxt     = (b == csvt_pkg::CHAR_CR);
        end
      end else begin
        prev_was_cr_nxt = 1'b0;
        if (!in_quotes_nxt && b == cfg.delimiter_char) begin
          if (in_word_nxt || last_was_delim_nxt) begin
            e = '{out_byte: 8'd0, byte_valid: 1'b0, field_end: 1'b1, record_end: 1'b0};
            if (cnt == 2'd0) r0 = e; else r1 = e;
            cnt = cnt + 2'd1;
          end
          in_word_nxt         = 1'b0;
          held_valid_nxt      = 1'b0;
          last_was_delim_nxt  = 1'b1;
          record_has_data_nxt = 1'b1;
        end else if (b == cfg.quote_char) begin
          prev_was_quote_nxt = 1'b1;
        end else begin
          do_put = 1'b1;
          put_b  = b;
        end
      end
    end

    // Content byte, preceded by a withheld pair quote if any.
    if (do_put) begin
      if (held_valid_nxt) begin
        e = '{out_byte: held_byte_nxt, byte_valid: 1'b1, field_end: 1'b0,
              record_end: 1'b0};
        if (cnt == 2'd0) r0 = e; else r1 = e;
        cnt = cnt + 2'd1;
        held_valid_nxt = 1'b0;
      end
      e = '{out_byte: put_b, byte_valid: 1'b1, field_end: 1'b0, record_end: 1'b0};
      if (cnt == 2'd0) r0 = e; else r1 = e;
      cnt = cnt + 2'd1;
      in_word_nxt         = 1'b1;
      last_was_delim_nxt  = 1'b0;
      record_has_data_nxt = 1'b1;
    end

    // End of text: resolve a pending quote, close the record, clear state.
    if (last) begin
      if (prev_was_quote_nxt) begin
        in_word_nxt         = 1'b1;
        record_has_data_nxt = 1'b1;
      end
      if (record_has_data_nxt) begin
        if (cnt == 2'd2) begin
          r1.field_end  = r1.field_end | in_word_nxt;
          r1.record_end = 1'b1;
        end else begin
          e = '{out_byte: 8'd0, byte_valid: 1'b0, field_end: in_word_nxt,
                record_end: 1'b1};
          if (cnt == 2'd0) r0 = e; else r1 = e;
          cnt = cnt + 2'd1;
        end
      end
      held_byte_nxt       = 8'd0;
      held_valid_nxt      = 1'b0;
      prev_was_quote_nxt  = 1'b0;
      in_quotes_nxt       = 1'b0;
      in_word_nxt         = 1'b0;
      last_was_delim_nxt  = 1'b0;
      record_has_data_nxt = 1'b0;
      prev_was_cr_nxt     = 1'b0;
    end

    push_data.two = (cnt == 2'd2);
    push_data.r0  = r0;
    push_data.r1  = r1;
  end

  assign push = accept && (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r       <= 8'd0;
      held_valid_r      <= 1'b0;
      prev_was_quote_r  <= 1'b0;
      in_quotes_r       <= 1'b0;
      in_word_r         <= 1'b0;
      last_was_delim_r  <= 1'b0;
      record_has_data_r <= 1'b0;
      prev_was_cr_r     <= 1'b0;
    end else if (accept) begin
      held_byte_r       <= held_byte_nxt;
      held_valid_r      <= held_valid_nxt;
      prev_was_quote_r  <= prev_was_quote_nxt;
      in_quotes_r       <= in_quotes_nxt;
      in_word_r         <= in_word_nxt;
      last_was_delim_r  <= last_was_delim_nxt;
      record_has_data_r <= record_has_data_nxt;
      prev_was_cr_r     <= prev_was_cr_nxt;
    end
  end

`ifndef SYNTH
  a_held_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> in_word_r)
    else $error("withheld quote outside an open field");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.in_last |=> !in_word_r && !in_quotes_r && !prev_was_quote_r &&
      !record_has_data_r)
    else $error("state not cleared after final byte");
`endif

endmodule

`default_nettype wire

// ----- hdl/csvt_fifo.sv -----
// Short result queue between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module csvt_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire csvt_pkg::entry_t     push_data,
  input  wire logic                 pop,
  output csvt_pkg::entry_t          head,
  output csvt_pkg::fifo_stat_t      fstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  csvt_pkg::entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign fstat.full  = (count_r == (AW+1)'(DEPTH));
  assign fstat.empty = (count_r == '0);
  assign head        = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fstat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fstat.empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- hdl/csvt_back.sv -----
// Back end: splits queue entries into single results behind an output register.
`timescale 1ns / 1ps
`default_nettype none

module csvt_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire csvt_pkg::entry_t     head,
  input  wire csvt_pkg::fifo_stat_t fstat,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output csvt_pkg::out_t            out_data
);

  logic           sel_r, sel_nxt;
  logic           out_valid_r, out_valid_nxt;
  csvt_pkg::out_t out_data_r, out_data_nxt;
  logic           load;

  assign load      = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    pop           = 1'b0;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (load && !fstat.empty) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = sel_r ? head.r1 : head.r0;
      if (sel_r || !head.two) begin
        pop     = 1'b1;
        sel_nxt = 1'b0;
      end else begin
        sel_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_second_pending: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> !fstat.empty && head.two)
    else $error("second result selected without a two-result entry");
`endif

endmodule

`default_nettype wire
